>>> hdl/sbef_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic for the stereo biquad.
package sbef_pkg;

    localparam int SBEF_NORM_SHIFT = 3;
    localparam int SBEF_IN_SHIFT   = 1;

    localparam int SBEF_CFG_IDX_W = 3;
    localparam int SBEF_TAP_W     = 3;

    // configuration register indexes
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_B0     = 3'd0;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_B1     = 3'd1;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_B2     = 3'd2;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_A1     = 3'd3;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_A2     = 3'd4;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_A0_NZ  = 3'd5;
    localparam logic [SBEF_CFG_IDX_W-1:0] CFG_BYPASS = 3'd6;

    // product order through the lane multiplier
    localparam logic [SBEF_TAP_W-1:0] TAP_B0  = 3'd0;
    localparam logic [SBEF_TAP_W-1:0] TAP_B1  = 3'd1;
    localparam logic [SBEF_TAP_W-1:0] TAP_B2  = 3'd2;
    localparam logic [SBEF_TAP_W-1:0] TAP_A1  = 3'd3;
    localparam logic [SBEF_TAP_W-1:0] TAP_A2  = 3'd4;
    localparam logic [SBEF_TAP_W-1:0] TAP_END = 3'd5;

    localparam logic signed [63:0] SAT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SAT64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] SAT32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] SAT32_MIN = {1'b1, {31{1'b0}}};

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_coef;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_st;

    // a + b or a - b, clamped to the 64-bit range
    function automatic logic signed [63:0] sat_acc(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic sub);
        logic signed [64:0] s;
        s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
        if (s[64] != s[63])
            return s[64] ? SAT64_MIN : SAT64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_shl64(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v <<< SBEF_NORM_SHIFT;
        if ((t >>> SBEF_NORM_SHIFT) != v)
            return v[63] ? SAT64_MIN : SAT64_MAX;
        return t;
    endfunction

    function automatic logic signed [31:0] sat_shl32(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v <<< SBEF_IN_SHIFT;
        if ((t >>> SBEF_IN_SHIFT) != v)
            return v[31] ? SAT32_MIN : SAT32_MAX;
        return t;
    endfunction

    function automatic logic signed [31:0] in_scale(input logic signed [31:0] v);
        return v >>> SBEF_IN_SHIFT;
    endfunction

endpackage

>>> hdl/sbef_lane.sv
`timescale 1ns / 1ps
// One biquad channel: shared 32x32 multiplier, saturating accumulator, history.
module sbef_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_ack,
    input  logic signed [31:0]   i_sample,
    input  sbef_pkg::t_coef      i_coef,
    output sbef_pkg::t_lane_st   o_st,
    output logic signed [31:0]   o_y
);
    import sbef_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_NORM = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [SBEF_TAP_W-1:0] r_cnt;

    logic signed [31:0] r_x0, r_x1, r_x2, r_y1, r_y2;
    logic        [31:0] r_err;
    logic signed [63:0] r_acc, r_prod;
    logic               r_prod_sub;
    logic signed [31:0] r_y;

    logic signed [31:0] w_mc, w_mo;
    logic signed [63:0] w_prod, w_shl;
    logic signed [31:0] w_hi;
    logic               w_load;

    assign w_load = i_start && (r_state == ST_IDLE || (r_state == ST_DONE && i_ack));

    always_comb begin
        w_mc = '0;
        w_mo = '0;
        unique case (r_cnt)
            TAP_B0: begin w_mc = i_coef.b0; w_mo = r_x0; end
            TAP_B1: begin w_mc = i_coef.b1; w_mo = r_x1; end
            TAP_B2: begin w_mc = i_coef.b2; w_mo = r_x2; end
            TAP_A1: begin w_mc = i_coef.a1; w_mo = r_y1; end
            TAP_A2: begin w_mc = i_coef.a2; w_mo = r_y2; end
            default: ;
        endcase
    end

    assign w_prod = 64'(w_mc) * 64'(w_mo);
    assign w_shl  = sat_shl64(r_acc);
    assign w_hi   = w_shl[63:32];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_MAC;
            ST_MAC:  if (r_cnt == TAP_END) n_state = ST_NORM;
            ST_NORM: n_state = ST_DONE;
            ST_DONE: if (i_ack) n_state = i_start ? ST_MAC : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
            r_err   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load)
                r_cnt <= TAP_B0;
            else if (r_state == ST_MAC)
                r_cnt <= r_cnt + 1'b1;
            if (r_state == ST_NORM) begin
                r_err <= r_acc[31:0];
                r_x2  <= r_x1;
                r_x1  <= r_x0;
                r_y2  <= r_y1;
                r_y1  <= w_hi;
            end
        end
    end

    // datapath: product of tap n is registered, then accumulated in the following cycle
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x0  <= in_scale(i_sample);
            r_acc <= {32'b0, r_err};
        end else if (r_state == ST_MAC) begin
            if (r_cnt != TAP_END) begin
                r_prod     <= w_prod;
                r_prod_sub <= (r_cnt >= TAP_A1);
            end
            if (r_cnt != TAP_B0)
                r_acc <= sat_acc(r_acc, r_prod, r_prod_sub);
        end
        if (r_state == ST_NORM)
            r_y <= sat_shl32(w_hi);
    end

    assign o_st.idle = (r_state == ST_IDLE);
    assign o_st.done = (r_state == ST_DONE);
    assign o_y       = r_y;

endmodule

>>> hdl/sbef_out.sv
`timescale 1ns / 1ps
// Output stage: merges the two lane results or a passed-through item.
module sbef_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_lane,
    input  logic                i_load_byp,
    input  logic signed [31:0]  i_lane_left,
    input  logic signed [31:0]  i_lane_right,
    input  logic                i_lane_last,
    input  logic signed [31:0]  i_byp_left,
    input  logic signed [31:0]  i_byp_right,
    input  logic                i_byp_last,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output logic signed [31:0]  o_left,
    output logic signed [31:0]  o_right,
    output logic                o_last
);
    import sbef_pkg::*;

    logic               r_vld;
    logic signed [31:0] r_left, r_right;
    logic               r_last;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= 1'b0;
        else if (i_load_lane || i_load_byp)
            r_vld <= 1'b1;
        else if (!i_stall)
            r_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        priority if (i_load_lane) begin
            r_left  <= i_lane_left;
            r_right <= i_lane_right;
            r_last  <= i_lane_last;
        end else if (i_load_byp) begin
            r_left  <= i_byp_left;
            r_right <= i_byp_right;
            r_last  <= i_byp_last;
        end
    end

    assign o_valid = r_vld;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_last  = r_last;

endmodule

>>> hdl/stereo_biquad_error_feedback.sv
`timescale 1ns / 1ps
// Top level of the stereo Q31 biquad with first-order error feedback.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | i_in_valid / o_in_stall    | i_left_in, i_right_in, i_last_in
//   output   | o_out_valid / i_out_stall  | o_left_out, o_right_out, o_last_out
//   config   | i_cfg_we (no handshake)    | i_cfg_idx, i_cfg_data
//
// Filtering: each lane's single multiplier and 64-bit saturating accumulator
// take one item at a time through start, five products plus trailing add,
// normalize and handover; a new item starts in the cycle its predecessor
// leaves for the output register. Bypass (or leading coefficient zero): an
// item goes straight out once lanes are idle and the output register is free.
// Reset is synchronous, active low: coefficients, flags, history and stored
// errors go to zero. One item waits in the input register while the lanes
// work; o_in_stall is high exactly while that register is full.
module stereo_biquad_error_feedback (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [31:0]                    i_left_in,
    input  logic signed [31:0]                    i_right_in,
    input  logic                                  i_last_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [31:0]                    o_left_out,
    output logic signed [31:0]                    o_right_out,
    output logic                                  o_last_out,
    input  logic                                  i_cfg_we,
    input  logic [sbef_pkg::SBEF_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                           i_cfg_data
);
    import sbef_pkg::*;

    // configuration registers
    t_coef r_coef;
    logic  r_a0_nz;
    logic  r_bypass;

    // input holding register
    logic               r_in_vld;
    logic signed [31:0] r_in_left, r_in_right;
    logic               r_in_last;
    logic               r_run_last;     // last flag of the item inside the lanes

    t_lane_st           w_st_l, w_st_r;
    logic signed [31:0] w_y_l, w_y_r;
    logic               w_filt, w_lanes_idle, w_lanes_done, w_out_free;
    logic               w_ack, w_start, w_byp, w_in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_a0_nz  <= 1'b0;
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_B0:     r_coef.b0 <= i_cfg_data;
                CFG_B1:     r_coef.b1 <= i_cfg_data;
                CFG_B2:     r_coef.b2 <= i_cfg_data;
                CFG_A1:     r_coef.a1 <= i_cfg_data;
                CFG_A2:     r_coef.a2 <= i_cfg_data;
                CFG_A0_NZ:  r_a0_nz   <= i_cfg_data[0];
                CFG_BYPASS: r_bypass  <= i_cfg_data[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign w_filt       = r_a0_nz && !r_bypass;
    assign w_lanes_idle = w_st_l.idle && w_st_r.idle;
    assign w_lanes_done = w_st_l.done && w_st_r.done;

    // lanes hand over their result and may take the next item in the same cycle
    assign w_ack    = w_lanes_done && w_out_free;
    assign w_start  = r_in_vld && w_filt && (w_lanes_idle || w_ack);
    // pass-through only once the lanes are empty, keeping item order
    assign w_byp    = r_in_vld && !w_filt && w_lanes_idle && w_out_free;
    assign w_in_acc = i_in_valid && !r_in_vld;

    assign o_in_stall = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_vld <= 1'b0;
        else if (w_in_acc)
            r_in_vld <= 1'b1;
        else if (w_start || w_byp)
            r_in_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_left  <= i_left_in;
            r_in_right <= i_right_in;
            r_in_last  <= i_last_in;
        end
        if (w_start)
            r_run_last <= r_in_last;
    end

    sbef_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_ack    (w_ack),
        .i_sample (r_in_left),
        .i_coef   (r_coef),
        .o_st     (w_st_l),
        .o_y      (w_y_l)
    );

    sbef_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_ack    (w_ack),
        .i_sample (r_in_right),
        .i_coef   (r_coef),
        .o_st     (w_st_r),
        .o_y      (w_y_r)
    );

    sbef_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_lane  (w_ack),
        .i_load_byp   (w_byp),
        .i_lane_left  (w_y_l),
        .i_lane_right (w_y_r),
        .i_lane_last  (r_run_last),
        .i_byp_left   (r_in_left),
        .i_byp_right  (r_in_right),
        .i_byp_last   (r_in_last),
        .i_stall      (i_out_stall),
        .o_free       (w_out_free),
        .o_valid      (o_out_valid),
        .o_left       (o_left_out),
        .o_right      (o_right_out),
        .o_last       (o_last_out)
    );

`ifndef NO_ASSERTIONS
    // both lanes run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_st_l.done == w_st_r.done) && (w_st_l.idle == w_st_r.idle))
        else $error("lanes out of step");

    // a started item is finished: both lanes reach their done state
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> ##8 w_lanes_done)
        else $error("lane result late");

    // never two sources into the output register at once
    a_one_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ack && w_byp))
        else $error("output register double load");
`endif

endmodule
